// ===== hw/rtl/mcprm_pkg.sv =====
// ----------------------------------------------------------------------------
// Power rail monitor package
// Shared types, register indexes, status codes and reset constants.
// ----------------------------------------------------------------------------
package mcprm_pkg;

  localparam int unsigned RAILS   = 5;
  localparam int unsigned RAIL_W  = 3;
  localparam int unsigned AVG_W   = 32;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned ACC_W   = AVG_W + WEIGHT_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [AVG_W-1:0]    CURRENT_BIAS = 32'h8000_0000;

  localparam logic [63:0] LIMITS_RESET [RAILS] = '{
    64'd2738252999733306368,
    64'd1152960159571513168,
    64'd1153003109609383136,
    64'd1152960160544606176,
    64'd1152960159480285616
  };
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd6554;

  typedef enum logic [2:0] {
    REG_LIMITS_0 = 3'd0,
    REG_LIMITS_1 = 3'd1,
    REG_LIMITS_2 = 3'd2,
    REG_LIMITS_3 = 3'd3,
    REG_LIMITS_4 = 3'd4,
    REG_V_WEIGHT = 3'd5,
    REG_C_WEIGHT = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    STATUS_UNKNOWN  = 3'd0,
    STATUS_NORMAL   = 3'd1,
    STATUS_CHARGING = 3'd2,
    STATUS_WARNING  = 3'd3,
    STATUS_CRITICAL = 3'd4,
    STATUS_DEGRADED = 3'd5
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_VA    = 7'b0000010,
    S_VB    = 7'b0000100,
    S_CA    = 7'b0001000,
    S_CB    = 7'b0010000,
    S_SCALE = 7'b0100000,
    S_DONE  = 7'b1000000
  } seq_state_e;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic accumulate;
  } mac_ctrl_t;

endpackage

// ===== hw/rtl/mcprm_if.sv =====
// ----------------------------------------------------------------------------
// Power rail monitor channels
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface mcprm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel;
  logic               sensor_present;
  logic [15:0]        bus_voltage;
  logic signed [15:0] bus_current;

  modport source (output valid, channel, sensor_present, bus_voltage, bus_current,
                  input ready);
  modport sink (input valid, channel, sensor_present, bus_voltage, bus_current,
                output ready);
endinterface

interface mcprm_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         rail;
  logic [2:0]         status;
  logic               status_changed;
  logic [15:0]        smoothed_voltage;
  logic signed [15:0] smoothed_current;
  logic               any_critical;
  logic               sample_used;

  modport source (output valid, rail, status, status_changed, smoothed_voltage,
                  smoothed_current, any_critical, sample_used, input ready);
  modport sink (input valid, rail, status, status_changed, smoothed_voltage,
                smoothed_current, any_critical, sample_used, output ready);
endinterface

interface mcprm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/multi_channel_power_rail_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-channel power rail monitor
// Per-rail exponential averaging of voltage and current with threshold status.
// ----------------------------------------------------------------------------
// Steps: a blended sample passes VA, VB, CA, CB, SCALE and DONE; a seeding or
// sensor-lost sample VA, SCALE, DONE; an out-of-range channel VA, DONE. DONE
// waits for the output register. A new sample is taken only in IDLE. The single
// shared 32x17 multiply-accumulate unit does four blend products, one scale.
// Reset: all rails return to unknown status with zero averages and unseeded,
// and the limit and weight registers take their default values.
module multi_channel_power_rail_monitor_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mcprm_in_if.sink             sample_i,
  mcprm_out_if.source          result_o,
  mcprm_cfg_if.sink            cfg_i
);

  localparam int unsigned AW = mcprm_pkg::AVG_W;
  localparam int unsigned WW = mcprm_pkg::WEIGHT_W;
  localparam int unsigned CW = mcprm_pkg::ACC_W;

  // Configuration registers
  logic [63:0]   limits_q [mcprm_pkg::RAILS];
  logic [WW-1:0] v_weight_q, c_weight_q;

  // Per-rail state
  logic [AW-1:0]        vavg_q [mcprm_pkg::RAILS];
  logic [AW-1:0]        cavg_q [mcprm_pkg::RAILS];
  mcprm_pkg::status_e   status_q [mcprm_pkg::RAILS];
  logic [mcprm_pkg::RAILS-1:0] seen_q;

  // Sequencer and latched sample
  mcprm_pkg::seq_state_e state_q, state_d;
  logic [2:0]  ch_q;
  logic        present_q;
  logic [15:0] volt_q;
  logic [15:0] curr_q;
  logic        blend_q;

  // Output register
  logic               out_valid_q;
  logic [2:0]         out_rail_q;
  mcprm_pkg::status_e out_status_q;
  logic               out_changed_q;
  logic [15:0]        out_volt_q;
  logic [15:0]        out_curr_q;
  logic               out_crit_q;
  logic               out_used_q;

  logic        in_range;
  logic [2:0]  idx;
  logic [WW-1:0] wv_eff, wc_eff;
  logic        can_out;

  mcprm_pkg::mac_ctrl_t mac_ctrl;
  logic [AW-1:0] mac_a;
  logic [WW-1:0] mac_b;
  logic [CW-1:0] acc;
  logic [CW-1:0] acc_round;
  logic [AW-1:0] blended;

  // Classification signals
  logic [47:0]  prod;
  logic [15:0]  lim_crit, lim_warn, lim_ilim;
  logic [AW-1:0] cur_avg;
  logic [AW-1:0] mag;
  mcprm_pkg::status_e next_status;
  logic [48:0]  scaled_sum;
  logic [20:0]  scaled;
  logic [15:0]  volt_sat;
  logic [16:0]  cur_round;
  logic         any_crit;

  assign in_range = ch_q < 3'(mcprm_pkg::RAILS);
  assign idx      = in_range ? ch_q : '0;
  assign wv_eff   = v_weight_q[WW-1] ? mcprm_pkg::WEIGHT_ONE : v_weight_q;
  assign wc_eff   = c_weight_q[WW-1] ? mcprm_pkg::WEIGHT_ONE : c_weight_q;
  assign can_out  = !out_valid_q || result_o.ready;

  assign sample_i.ready = (state_q == mcprm_pkg::S_IDLE);
  assign cfg_i.ready    = 1'b1;

  // Operand selection for the shared unit.
  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    case (state_q)
      mcprm_pkg::S_VA: begin
        mac_ctrl.en = in_range && present_q && seen_q[idx];
        mac_a       = {volt_q, 16'h0000};
        mac_b       = wv_eff;
      end
      mcprm_pkg::S_VB: begin
        mac_ctrl = '{en: 1'b1, accumulate: 1'b1};
        mac_a    = vavg_q[idx];
        mac_b    = mcprm_pkg::WEIGHT_ONE - wv_eff;
      end
      mcprm_pkg::S_CA: begin
        mac_ctrl.en = 1'b1;
        mac_a       = {curr_q, 16'h0000};
        mac_b       = wc_eff;
      end
      mcprm_pkg::S_CB: begin
        mac_ctrl = '{en: 1'b1, accumulate: 1'b1};
        mac_a    = cavg_q[idx];
        mac_b    = mcprm_pkg::WEIGHT_ONE - wc_eff;
      end
      mcprm_pkg::S_SCALE: begin
        mac_ctrl.en = 1'b1;
        mac_a       = vavg_q[idx];
        mac_b       = {1'b0, limits_q[idx][63:48]};
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  mcprm_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // The blended sum stays below 2^48, so rounding cannot overflow.
  assign acc_round = acc + CW'(32768);
  assign blended   = acc_round[47:16];

  // Classification uses the product left by the scale step.
  assign prod     = acc[47:0];
  assign lim_crit = limits_q[idx][15:0];
  assign lim_warn = limits_q[idx][31:16];
  assign lim_ilim = limits_q[idx][47:32];
  assign cur_avg  = cavg_q[idx];
  assign mag      = cur_avg[AW-1] ? (cur_avg - mcprm_pkg::CURRENT_BIAS)
                                  : (mcprm_pkg::CURRENT_BIAS - cur_avg);

  always_comb begin
    if (!present_q) begin
      next_status = mcprm_pkg::STATUS_DEGRADED;
    end else if ((prod[47:28] < {4'h0, lim_crit}) || (mag > {lim_ilim, 16'h0000})) begin
      next_status = mcprm_pkg::STATUS_CRITICAL;
    end else if (prod[47:28] < {4'h0, lim_warn}) begin
      next_status = mcprm_pkg::STATUS_WARNING;
    end else if ((idx == '0) && !cur_avg[AW-1]) begin
      next_status = mcprm_pkg::STATUS_CHARGING;
    end else begin
      next_status = mcprm_pkg::STATUS_NORMAL;
    end
  end

  assign scaled_sum = {1'b0, prod} + 49'(1 << 27);
  assign scaled     = scaled_sum[48:28];
  assign volt_sat   = (|scaled[20:16]) ? 16'hFFFF : scaled[15:0];
  assign cur_round  = ({1'b0, cur_avg[31:16]}) + 17'(cur_avg[15]);
  // Removing the offset of 32768 flips the sign bit.
  always_comb begin
    any_crit = 1'b0;
    for (int i = 0; i < mcprm_pkg::RAILS; i++) begin
      if (in_range && (3'(i) == idx)) begin
        any_crit = any_crit || (next_status == mcprm_pkg::STATUS_CRITICAL);
      end else begin
        any_crit = any_crit || (status_q[i] == mcprm_pkg::STATUS_CRITICAL);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcprm_pkg::S_IDLE: begin
        if (sample_i.valid) begin
          state_d = mcprm_pkg::S_VA;
        end
      end
      mcprm_pkg::S_VA: begin
        if (!in_range) begin
          state_d = mcprm_pkg::S_DONE;
        end else if (present_q && seen_q[idx]) begin
          state_d = mcprm_pkg::S_VB;
        end else begin
          state_d = mcprm_pkg::S_SCALE;
        end
      end
      mcprm_pkg::S_VB:    state_d = mcprm_pkg::S_CA;
      mcprm_pkg::S_CA:    state_d = mcprm_pkg::S_CB;
      mcprm_pkg::S_CB:    state_d = mcprm_pkg::S_SCALE;
      mcprm_pkg::S_SCALE: state_d = mcprm_pkg::S_DONE;
      mcprm_pkg::S_DONE: begin
        if (can_out) begin
          state_d = mcprm_pkg::S_IDLE;
        end
      end
      default: state_d = mcprm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcprm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sample latch
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      ch_q      <= sample_i.channel;
      present_q <= sample_i.sensor_present;
      volt_q    <= sample_i.bus_voltage;
      curr_q    <= sample_i.bus_current ^ 16'h8000;
    end
    if (state_q == mcprm_pkg::S_VA) begin
      blend_q <= in_range && present_q && seen_q[idx];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mcprm_pkg::RAILS; i++) begin
        limits_q[i] <= mcprm_pkg::LIMITS_RESET[i];
      end
      v_weight_q <= mcprm_pkg::WEIGHT_RESET;
      c_weight_q <= mcprm_pkg::WEIGHT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (mcprm_pkg::cfg_reg_e'(cfg_i.index))
        mcprm_pkg::REG_LIMITS_0, mcprm_pkg::REG_LIMITS_1, mcprm_pkg::REG_LIMITS_2,
        mcprm_pkg::REG_LIMITS_3, mcprm_pkg::REG_LIMITS_4: begin
          limits_q[cfg_i.index] <= cfg_i.data;
        end
        mcprm_pkg::REG_V_WEIGHT: v_weight_q <= cfg_i.data[WW-1:0];
        mcprm_pkg::REG_C_WEIGHT: c_weight_q <= cfg_i.data[WW-1:0];
        default: ;
      endcase
    end
  end

  // Per-rail averages, status and seed flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mcprm_pkg::RAILS; i++) begin
        vavg_q[i]   <= '0;
        cavg_q[i]   <= mcprm_pkg::CURRENT_BIAS;
        status_q[i] <= mcprm_pkg::STATUS_UNKNOWN;
      end
      seen_q <= '0;
    end else begin
      case (state_q)
        mcprm_pkg::S_VA: begin
          // The first sample a rail takes with its sensor present seeds both averages.
          if (in_range && present_q && !seen_q[idx]) begin
            vavg_q[idx] <= {volt_q, 16'h0000};
            cavg_q[idx] <= {curr_q, 16'h0000};
            seen_q[idx] <= 1'b1;
          end
        end
        mcprm_pkg::S_CA: begin
          vavg_q[idx] <= blended;
        end
        mcprm_pkg::S_SCALE: begin
          if (blend_q) begin
            cavg_q[idx] <= blended;
          end
        end
        mcprm_pkg::S_DONE: begin
          if (can_out && in_range) begin
            status_q[idx] <= next_status;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == mcprm_pkg::S_DONE) && can_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == mcprm_pkg::S_DONE) && can_out) begin
      out_rail_q <= ch_q;
      out_crit_q <= any_crit;
      if (in_range) begin
        out_status_q  <= next_status;
        out_changed_q <= next_status != status_q[idx];
        out_volt_q    <= volt_sat;
        out_curr_q    <= cur_round[15:0] ^ 16'h8000;
        out_used_q    <= present_q;
      end else begin
        out_status_q  <= mcprm_pkg::STATUS_UNKNOWN;
        out_changed_q <= 1'b0;
        out_volt_q    <= '0;
        out_curr_q    <= '0;
        out_used_q    <= 1'b0;
      end
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.rail             = out_rail_q;
  assign result_o.status           = out_status_q;
  assign result_o.status_changed   = out_changed_q;
  assign result_o.smoothed_voltage = out_volt_q;
  assign result_o.smoothed_current = out_curr_q;
  assign result_o.any_critical     = out_crit_q;
  assign result_o.sample_used      = out_used_q;

endmodule

// ===== hw/rtl/mcprm_mac.sv =====
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// 32 x 17 bit unsigned multiply, either loaded or added into the accumulator.
// ----------------------------------------------------------------------------
module mcprm_mac (
  input  logic                                clk_i,
  input  mcprm_pkg::mac_ctrl_t                ctrl_i,
  input  logic [mcprm_pkg::AVG_W-1:0]         a_i,
  input  logic [mcprm_pkg::WEIGHT_W-1:0]      b_i,
  output logic [mcprm_pkg::ACC_W-1:0]         acc_o
);

  logic [mcprm_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [mcprm_pkg::ACC_W-1:0] prod;

  assign prod = mcprm_pkg::ACC_W'(a_i) * mcprm_pkg::ACC_W'(b_i);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.en) begin
      acc_d = (ctrl_i.accumulate ? acc_q : '0) + prod;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
